[hw/rtl/qpr_pkg.sv]
// Shared types, constants and helpers for the quaternion product/rotate core.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
`default_nettype none

package qpr_pkg;

  // Component format
  localparam int unsigned Q_W       = 32;
  localparam int unsigned EXT_W     = Q_W + 1;  // one spare bit for negation and sums
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned FRAC_BITS = 16;

  // Component order inside the four-entry arrays
  localparam int unsigned NCOMP = 4;
  localparam int unsigned IX    = 0;
  localparam int unsigned IY    = 1;
  localparam int unsigned IZ    = 2;
  localparam int unsigned IW    = 3;

  typedef logic signed [Q_W-1:0]   comp_t;
  typedef logic signed [EXT_W-1:0] ext_t;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PROD = 3'd0,
    KIND_ROT  = 3'd1,
    KIND_ADD  = 3'd2,
    KIND_SUB  = 3'd3,
    KIND_CONJ = 3'd4
  } kind_t;

  typedef struct packed {
    logic  flag;
    comp_t val;
  } sat_t;

  // Clamp a 33-bit value to the 32-bit range
  function automatic sat_t sat_ext(input ext_t v);
    sat_t res;
    res.flag = (v[EXT_W-1] != v[EXT_W-2]);
    if (!res.flag) begin
      res.val = v[Q_W-1:0];
    end else if (v[EXT_W-1]) begin
      res.val = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res.val = {1'b0, {(Q_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Sign-extend one component by a bit
  function automatic ext_t sext(input comp_t v);
    return {v[Q_W-1], v};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/qpr_in_if.sv]
// Request channel of the quaternion core: operation kind plus quaternions a and b.
// Depends on qpr_pkg for widths.
`default_nettype none

interface qpr_in_if;
  logic                         valid;
  logic                         ready;
  logic [qpr_pkg::KIND_W-1:0]   kind;
  logic signed [qpr_pkg::Q_W-1:0] a_x;
  logic signed [qpr_pkg::Q_W-1:0] a_y;
  logic signed [qpr_pkg::Q_W-1:0] a_z;
  logic signed [qpr_pkg::Q_W-1:0] a_w;
  logic signed [qpr_pkg::Q_W-1:0] b_x;
  logic signed [qpr_pkg::Q_W-1:0] b_y;
  logic signed [qpr_pkg::Q_W-1:0] b_z;
  logic signed [qpr_pkg::Q_W-1:0] b_w;

  modport source (output valid, kind, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink   (input valid, kind, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/qpr_out_if.sv]
// Result channel of the quaternion core: four components plus saturation flag.
// Depends on qpr_pkg for widths.
`default_nettype none

interface qpr_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [qpr_pkg::Q_W-1:0] r_x;
  logic signed [qpr_pkg::Q_W-1:0] r_y;
  logic signed [qpr_pkg::Q_W-1:0] r_z;
  logic signed [qpr_pkg::Q_W-1:0] r_w;
  logic                           saturated;

  modport source (output valid, r_x, r_y, r_z, r_w, saturated, input ready);
  modport sink   (input valid, r_x, r_y, r_z, r_w, saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/qpr_ham.sv]
// Two-stage pipelined Hamilton product p*q in fixed point with 32-bit saturation.
// Depends on qpr_pkg; stage enables come from the owner's pipeline control.
`default_nettype none

module qpr_ham #(
  parameter int unsigned OPW       = qpr_pkg::EXT_W,
  parameter int unsigned FRAC_BITS = qpr_pkg::FRAC_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            en_mul,
  input  wire logic                            en_sum,
  input  wire logic signed [OPW-1:0]           p [qpr_pkg::NCOMP],
  input  wire logic signed [OPW-1:0]           q [qpr_pkg::NCOMP],
  output logic signed [qpr_pkg::Q_W-1:0]       r [qpr_pkg::NCOMP],
  output logic                                 sat
);

  localparam int unsigned PRW  = 2 * OPW;
  localparam int unsigned SHW  = PRW - FRAC_BITS;
  localparam int unsigned SUMW = SHW + 2;
  localparam int unsigned QW   = qpr_pkg::Q_W;
  localparam int unsigned NC   = qpr_pkg::NCOMP;
  localparam int unsigned X    = qpr_pkg::IX;
  localparam int unsigned Y    = qpr_pkg::IY;
  localparam int unsigned Z    = qpr_pkg::IZ;
  localparam int unsigned W    = qpr_pkg::IW;

  // Stage A: sixteen full-width products, floor-shifted by the fraction bits
  logic signed [SHW-1:0] mul_r [NC][NC];

  for (genvar i = 0; i < NC; i++) begin : g_row
    for (genvar j = 0; j < NC; j++) begin : g_col
      logic signed [PRW-1:0] prod;
      logic signed [PRW-1:0] prod_sh;
      assign prod    = p[i] * q[j];
      assign prod_sh = prod >>> FRAC_BITS;
      always_ff @(posedge clk) begin
        if (en_mul) begin
          mul_r[i][j] <= prod_sh[SHW-1:0];
        end
      end
    end
  end

  // Stage B: signed four-term sums per component
  logic signed [SUMW-1:0] sum [NC];

  always_comb begin
    sum[W] = SUMW'(mul_r[W][W]) - SUMW'(mul_r[X][X])
           - SUMW'(mul_r[Y][Y]) - SUMW'(mul_r[Z][Z]);
    sum[X] = SUMW'(mul_r[W][X]) + SUMW'(mul_r[X][W])
           + SUMW'(mul_r[Y][Z]) - SUMW'(mul_r[Z][Y]);
    sum[Y] = SUMW'(mul_r[W][Y]) - SUMW'(mul_r[X][Z])
           + SUMW'(mul_r[Y][W]) + SUMW'(mul_r[Z][X]);
    sum[Z] = SUMW'(mul_r[W][Z]) + SUMW'(mul_r[X][Y])
           - SUMW'(mul_r[Y][X]) + SUMW'(mul_r[Z][W]);
  end

  // Clamp each sum to 32 bits
  logic signed [QW-1:0] r_nxt [NC];
  logic [NC-1:0]        clip;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      clip[i] = 1'b0;
      r_nxt[i] = sum[i][QW-1:0];
      if (!sum[i][SUMW-1] && (|sum[i][SUMW-2:QW-1])) begin
        clip[i]  = 1'b1;
        r_nxt[i] = {1'b0, {(QW-1){1'b1}}};
      end else if (sum[i][SUMW-1] && !(&sum[i][SUMW-2:QW-1])) begin
        clip[i]  = 1'b1;
        r_nxt[i] = {1'b1, {(QW-1){1'b0}}};
      end
    end
  end

  logic signed [QW-1:0] r_r [NC];
  logic                 sat_r;

  always_ff @(posedge clk) begin
    if (en_sum) begin
      r_r   <= r_nxt;
      sat_r <= |clip;
    end
  end

  assign r   = r_r;
  assign sat = sat_r;

endmodule

`default_nettype wire

[hw/rtl/quaternion_product_and_rotate_core.sv]
// Top level of the fixed-point quaternion unit: Hamilton product, vector rotation,
// add, subtract and conjugate. Depends on qpr_pkg, qpr_in_if, qpr_out_if, qpr_ham.
//
// Usage:
//   in_req  (qpr_in_if.sink): a request carries kind and quaternions a, b in
//           signed Q16.16. A request is taken when valid and ready are both high.
//   out_rsp (qpr_out_if.source): one result per request, r_x..r_w and the
//           saturated flag, in request order.
//   Pipeline: six register stages lie between the edge that takes a request and
//   its result on out_rsp (input register, two stages per Hamilton product,
//   output register).
//   Throughput: one request per cycle unless stalled. The rotation runs its two
//   Hamilton products in series through two product units, each a multiply
//   stage of sixteen parallel multipliers followed by a sum-and-clamp stage.
//   Reset (rst_n low, synchronous) empties the pipeline; data registers are not reset.
//   Stall: when out_rsp.ready is low the result holds and the pipeline keeps
//   filling into any empty stages; in_req.ready falls only once every stage
//   is full.
`default_nettype none

module quaternion_product_and_rotate_core #(
  parameter int unsigned FRAC_BITS = qpr_pkg::FRAC_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  qpr_in_if.sink      in_req,
  qpr_out_if.source   out_rsp
);

  localparam int unsigned NC = qpr_pkg::NCOMP;
  localparam int unsigned KW = qpr_pkg::KIND_W;

  // ---------------------------------------------------------------- control
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_v_r;
  logic en1, en2, en3, en4, en5, out_en;

  assign out_en = !out_v_r || out_rsp.ready;
  assign en5    = !v5_r || out_en;
  assign en4    = !v4_r || en5;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;

  assign in_req.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1)    v1_r    <= in_req.valid;
      if (en2)    v2_r    <= v1_r;
      if (en3)    v3_r    <= v2_r;
      if (en4)    v4_r    <= v3_r;
      if (en5)    v5_r    <= v4_r;
      if (out_en) out_v_r <= v5_r;
    end
  end

  // ---------------------------------------------------------- stage 1: input
  logic [KW-1:0]  k1_r, k2_r, k3_r, k4_r, k5_r;
  qpr_pkg::comp_t a1_r [NC];
  qpr_pkg::comp_t b1_r [NC];
  qpr_pkg::comp_t a2_r [NC];
  qpr_pkg::comp_t a3_r [NC];

  always_ff @(posedge clk) begin
    if (en1) begin
      k1_r     <= in_req.kind;
      a1_r[qpr_pkg::IX] <= in_req.a_x;
      a1_r[qpr_pkg::IY] <= in_req.a_y;
      a1_r[qpr_pkg::IZ] <= in_req.a_z;
      a1_r[qpr_pkg::IW] <= in_req.a_w;
      b1_r[qpr_pkg::IX] <= in_req.b_x;
      b1_r[qpr_pkg::IY] <= in_req.b_y;
      b1_r[qpr_pkg::IZ] <= in_req.b_z;
      b1_r[qpr_pkg::IW] <= in_req.b_w;
    end
  end

  // -------------------------------------------- first product: a * b (or a*v)
  qpr_pkg::ext_t  h1_p [NC];
  qpr_pkg::ext_t  h1_q [NC];
  qpr_pkg::comp_t h1_r [NC];
  logic           h1_sat;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      h1_p[i] = qpr_pkg::sext(a1_r[i]);
      h1_q[i] = qpr_pkg::sext(b1_r[i]);
    end
    // rotation uses the pure quaternion (b.xyz, 0)
    if (qpr_pkg::kind_t'(k1_r) == qpr_pkg::KIND_ROT) begin
      h1_q[qpr_pkg::IW] = '0;
    end
  end

  qpr_ham #(
    .OPW       (qpr_pkg::EXT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_ham1 (
    .clk    (clk),
    .en_mul (en2),
    .en_sum (en3),
    .p      (h1_p),
    .q      (h1_q),
    .r      (h1_r),
    .sat    (h1_sat)
  );

  // ----------------------------------- stage 2: add / subtract / conjugate
  qpr_pkg::comp_t alt_nxt [NC];
  logic [NC-1:0]  alt_clip;
  qpr_pkg::ext_t  add_s, sub_s, neg_s;
  qpr_pkg::sat_t  add_c, sub_c, neg_c;

  always_comb begin
    add_s = '0;
    sub_s = '0;
    neg_s = '0;
    add_c = '0;
    sub_c = '0;
    neg_c = '0;
    for (int i = 0; i < NC; i++) begin
      add_s = qpr_pkg::sext(a1_r[i]) + qpr_pkg::sext(b1_r[i]);
      sub_s = qpr_pkg::sext(a1_r[i]) - qpr_pkg::sext(b1_r[i]);
      neg_s = -qpr_pkg::sext(a1_r[i]);
      add_c = qpr_pkg::sat_ext(add_s);
      sub_c = qpr_pkg::sat_ext(sub_s);
      neg_c = qpr_pkg::sat_ext(neg_s);
      alt_nxt[i]  = '0;
      alt_clip[i] = 1'b0;
      unique case (qpr_pkg::kind_t'(k1_r))
        qpr_pkg::KIND_ADD: begin
          alt_nxt[i]  = add_c.val;
          alt_clip[i] = add_c.flag;
        end
        qpr_pkg::KIND_SUB: begin
          alt_nxt[i]  = sub_c.val;
          alt_clip[i] = sub_c.flag;
        end
        qpr_pkg::KIND_CONJ: begin
          if (i == qpr_pkg::IW) begin
            alt_nxt[i] = a1_r[i];
          end else begin
            alt_nxt[i]  = neg_c.val;
            alt_clip[i] = neg_c.flag;
          end
        end
        default: begin
          alt_nxt[i]  = '0;
          alt_clip[i] = 1'b0;
        end
      endcase
    end
  end

  qpr_pkg::comp_t alt2_r [NC];
  qpr_pkg::comp_t alt3_r [NC];
  qpr_pkg::comp_t alt4_r [NC];
  qpr_pkg::comp_t alt5_r [NC];
  logic           alt2_sat_r, alt3_sat_r, alt4_sat_r, alt5_sat_r;

  // sideband carried alongside the product units
  always_ff @(posedge clk) begin
    if (en2) begin
      k2_r       <= k1_r;
      a2_r       <= a1_r;
      alt2_r     <= alt_nxt;
      alt2_sat_r <= |alt_clip;
    end
    if (en3) begin
      k3_r       <= k2_r;
      a3_r       <= a2_r;
      alt3_r     <= alt2_r;
      alt3_sat_r <= alt2_sat_r;
    end
    if (en4) begin
      k4_r       <= k3_r;
      alt4_r     <= alt3_r;
      alt4_sat_r <= alt3_sat_r;
    end
    if (en5) begin
      k5_r       <= k4_r;
      alt5_r     <= alt4_r;
      alt5_sat_r <= alt4_sat_r;
    end
  end

  // -------------------------------------------- second product: t * conj(a)
  qpr_pkg::ext_t  h2_p [NC];
  qpr_pkg::ext_t  h2_q [NC];
  qpr_pkg::comp_t h2_r [NC];
  logic           h2_sat;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      h2_p[i] = qpr_pkg::sext(h1_r[i]);
      // exact conjugate, one bit wider so -2^31 negates without clamping
      if (i == qpr_pkg::IW) begin
        h2_q[i] = qpr_pkg::sext(a3_r[i]);
      end else begin
        h2_q[i] = -qpr_pkg::sext(a3_r[i]);
      end
    end
  end

  qpr_ham #(
    .OPW       (qpr_pkg::EXT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_ham2 (
    .clk    (clk),
    .en_mul (en4),
    .en_sum (en5),
    .p      (h2_p),
    .q      (h2_q),
    .r      (h2_r),
    .sat    (h2_sat)
  );

  // first product result rides along to the output stage
  qpr_pkg::comp_t h1_4_r [NC];
  qpr_pkg::comp_t h1_5_r [NC];
  logic           h1_sat4_r, h1_sat5_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      h1_4_r    <= h1_r;
      h1_sat4_r <= h1_sat;
    end
    if (en5) begin
      h1_5_r    <= h1_4_r;
      h1_sat5_r <= h1_sat4_r;
    end
  end

  // ----------------------------------------------- output select and register
  qpr_pkg::comp_t res_nxt [NC];
  logic           res_sat_nxt;

  always_comb begin
    res_nxt     = '{default: '0};
    res_sat_nxt = 1'b0;
    unique case (qpr_pkg::kind_t'(k5_r))
      qpr_pkg::KIND_PROD: begin
        res_nxt     = h1_5_r;
        res_sat_nxt = h1_sat5_r;
      end
      qpr_pkg::KIND_ROT: begin
        res_nxt              = h2_r;
        res_nxt[qpr_pkg::IW] = '0;
        res_sat_nxt          = h1_sat5_r | h2_sat;
      end
      qpr_pkg::KIND_ADD, qpr_pkg::KIND_SUB, qpr_pkg::KIND_CONJ: begin
        res_nxt     = alt5_r;
        res_sat_nxt = alt5_sat_r;
      end
      default: begin
        res_nxt     = '{default: '0};
        res_sat_nxt = 1'b0;
      end
    endcase
  end

  qpr_pkg::comp_t res_r [NC];
  logic           res_sat_r;
  logic [KW-1:0]  res_kind_r;

  always_ff @(posedge clk) begin
    if (out_en) begin
      res_r      <= res_nxt;
      res_sat_r  <= res_sat_nxt;
      res_kind_r <= k5_r;
    end
  end

  assign out_rsp.valid     = out_v_r;
  assign out_rsp.r_x       = res_r[qpr_pkg::IX];
  assign out_rsp.r_y       = res_r[qpr_pkg::IY];
  assign out_rsp.r_z       = res_r[qpr_pkg::IZ];
  assign out_rsp.r_w       = res_r[qpr_pkg::IW];
  assign out_rsp.saturated = res_sat_r;

  // --------------------------------------------------------------- checks
  // A full stage 5 that cannot advance means the output register is occupied
  a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !en5) |-> out_v_r)
    else $error("stage 5 blocked while output register empty");

  // Refusing a request only happens with the input stage occupied
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> v1_r)
    else $error("input refused with empty input stage");

  // Rotation results always carry a zero real part
  a_rot_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (qpr_pkg::kind_t'(res_kind_r) == qpr_pkg::KIND_ROT)) |-> (out_rsp.r_w == '0))
    else $error("rotation result with nonzero real part");

  // Unused operation codes give an all-zero result
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_kind_r > KW'(qpr_pkg::KIND_CONJ)))
      |-> (out_rsp.r_x == '0 && out_rsp.r_y == '0 && out_rsp.r_z == '0 &&
           out_rsp.r_w == '0 && !out_rsp.saturated))
    else $error("unused operation code gave nonzero result");

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking bench for quaternion_product_and_rotate_core: a directed table, then random
// requests, scored against a fixed-point quaternion predictor in this file unless a
// table row types its result. Depends on qpr_pkg, qpr_in_if, qpr_out_if and the core.
`timescale 1ns / 1ps

module tb;
  import qpr_pkg::*;

  // Request and result as the bench keeps them
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    comp_t a_x, a_y, a_z, a_w;
    comp_t b_x, b_y, b_z, b_w;
  } req_t;

  typedef struct packed {
    comp_t r_x, r_y, r_z, r_w;
    logic  sat;
  } res_t;

  typedef struct packed {
    req_t req;
    logic known;  // result typed into the table
    res_t res;
  } dir_row_t;

  typedef struct {
    longint x, y, z, w;
  } quad_t;

  typedef logic signed [65:0] wide_t;

  localparam logic [KIND_W-1:0] KIND_RSV5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSV6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSV7 = 3'd7;

  localparam comp_t Q_ONE = 32'sh0001_0000;
  localparam comp_t Q_MX  = 32'sh7FFF_FFFF;
  localparam comp_t Q_MN  = 32'sh8000_0000;
  localparam comp_t Q_M1  = -32'sd1;
  localparam comp_t Q_S45 = 32'sd46341;  // sin(45 deg)

  localparam longint Q_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_LO = 64'shFFFF_FFFF_8000_0000;

  localparam res_t NO_RES   = '0;
  localparam int   NDIR     = 24;
  localparam int   NRAND    = 500;
  localparam int   HOLD_CYC = 64;

  // Directed requests; rows with known=0 are scored by the predictor
  localparam dir_row_t DIR_TAB [NDIR] = '{
    '{'{KIND_PROD, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE}, 1'b1, '{0, 0, 0, Q_ONE, 1'b0}},
    '{'{KIND_PROD, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0}, 1'b1, '{0, 0, Q_ONE, 0, 1'b0}},
    '{'{KIND_PROD, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX}, 1'b0, NO_RES},
    '{'{KIND_PROD, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN}, 1'b0, NO_RES},
    '{'{KIND_PROD, Q_MN, Q_MX, Q_MN, Q_MX, Q_MX, Q_MN, Q_MX, Q_MN}, 1'b0, NO_RES},
    '{'{KIND_PROD, Q_M1, Q_M1, Q_M1, Q_M1, Q_ONE, Q_M1, Q_MX, Q_MN}, 1'b0, NO_RES},
    '{'{KIND_ROT, 0, 0, 0, Q_ONE, Q_ONE, 32'sh0002_0000, 32'shFFFD_0000, Q_MX}, 1'b1,
      '{Q_ONE, 32'sh0002_0000, 32'shFFFD_0000, 0, 1'b0}},
    '{'{KIND_ROT, Q_MN, Q_MN, Q_MN, Q_MN, Q_MX, Q_MX, Q_MX, Q_MX}, 1'b0, NO_RES},
    '{'{KIND_ROT, Q_MX, Q_MN, Q_MX, Q_MN, Q_MN, Q_MN, Q_MN, 0}, 1'b0, NO_RES},
    '{'{KIND_ROT, 0, 0, Q_S45, Q_S45, Q_ONE, 0, 0, 0}, 1'b0, NO_RES},
    '{'{KIND_ADD, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX}, 1'b1,
      '{Q_MX, Q_MX, Q_MX, Q_MX, 1'b1}},
    '{'{KIND_ADD, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN}, 1'b1,
      '{Q_MN, Q_MN, Q_MN, Q_MN, 1'b1}},
    '{'{KIND_ADD, Q_MX, Q_MN, 0, Q_ONE, Q_MN, Q_MX, 0, Q_M1}, 1'b1,
      '{Q_M1, Q_M1, 0, 32'sh0000_FFFF, 1'b0}},
    '{'{KIND_ADD, 0, 0, 0, Q_MX, 0, 0, 0, Q_ONE}, 1'b1, '{0, 0, 0, Q_MX, 1'b1}},
    '{'{KIND_SUB, Q_MN, Q_MN, Q_MN, Q_MN, Q_MX, Q_MX, Q_MX, Q_MX}, 1'b1,
      '{Q_MN, Q_MN, Q_MN, Q_MN, 1'b1}},
    '{'{KIND_SUB, Q_MX, Q_MX, Q_MX, Q_MX, Q_MN, Q_MN, Q_MN, Q_MN}, 1'b1,
      '{Q_MX, Q_MX, Q_MX, Q_MX, 1'b1}},
    '{'{KIND_SUB, 32'sd5, -32'sd7, Q_MX, Q_MN, 32'sd5, -32'sd7, Q_MX, Q_MN}, 1'b1,
      '{0, 0, 0, 0, 1'b0}},
    '{'{KIND_SUB, 0, 0, 0, 0, Q_MN, 0, 0, 0}, 1'b1, '{Q_MX, 0, 0, 0, 1'b1}},
    '{'{KIND_CONJ, Q_MN, Q_MN, Q_MN, Q_MN, Q_MX, Q_MX, Q_MX, Q_MX}, 1'b1,
      '{Q_MX, Q_MX, Q_MX, Q_MN, 1'b1}},
    '{'{KIND_CONJ, Q_MX, Q_MX, Q_MX, Q_MX, 0, 0, 0, 0}, 1'b1,
      '{32'sh8000_0001, 32'sh8000_0001, 32'sh8000_0001, Q_MX, 1'b0}},
    '{'{KIND_CONJ, Q_ONE, Q_M1, 0, 32'sd5, Q_MN, Q_MN, Q_MN, Q_MN}, 1'b1,
      '{32'shFFFF_0000, 32'sd1, 0, 32'sd5, 1'b0}},
    '{'{KIND_RSV5, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX, Q_MX}, 1'b1, NO_RES},
    '{'{KIND_RSV6, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN, Q_MN}, 1'b1, NO_RES},
    '{'{KIND_RSV7, Q_ONE, Q_M1, Q_ONE, Q_M1, Q_MN, Q_MX, Q_M1, Q_ONE}, 1'b1, NO_RES}
  };

  logic clk;
  logic rst_n;

  qpr_in_if  in_ch ();
  qpr_out_if out_ch ();

  quaternion_product_and_rotate_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_rsp (out_ch)
  );

  res_t pending_results [$];
  int   n_taken = 0;
  int   n_err   = 0;
  bit   no_gap  = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point quaternion predictor
  // ---------------------------------------------------------------------------

  // Full-width product, then floor shift by the fraction width
  function automatic longint mul_q(input longint p, input longint q);
    wide_t prod;
    prod = wide_t'(p) * wide_t'(q);
    return longint'(prod >>> FRAC_BITS);
  endfunction

  function automatic longint clamp32(input longint v, inout bit hit);
    if (v > Q_HI) begin
      hit = 1'b1;
      return Q_HI;
    end
    if (v < Q_LO) begin
      hit = 1'b1;
      return Q_LO;
    end
    return v;
  endfunction

  function automatic quad_t hamilton_mul(input quad_t p, input quad_t q, inout bit hit);
    quad_t r;
    r.w = clamp32(mul_q(p.w, q.w) - mul_q(p.x, q.x) - mul_q(p.y, q.y) - mul_q(p.z, q.z), hit);
    r.x = clamp32(mul_q(p.w, q.x) + mul_q(p.x, q.w) + mul_q(p.y, q.z) - mul_q(p.z, q.y), hit);
    r.y = clamp32(mul_q(p.w, q.y) - mul_q(p.x, q.z) + mul_q(p.y, q.w) + mul_q(p.z, q.x), hit);
    r.z = clamp32(mul_q(p.w, q.z) + mul_q(p.x, q.y) - mul_q(p.y, q.x) + mul_q(p.z, q.w), hit);
    return r;
  endfunction

  function automatic res_t quat_result(input req_t q);
    quad_t a, b, v, c, t, r;
    bit    hit;
    res_t  res;
    hit = 1'b0;
    a = '{longint'(q.a_x), longint'(q.a_y), longint'(q.a_z), longint'(q.a_w)};
    b = '{longint'(q.b_x), longint'(q.b_y), longint'(q.b_z), longint'(q.b_w)};
    r = '{0, 0, 0, 0};
    case (q.kind)
      KIND_PROD: r = hamilton_mul(a, b, hit);
      KIND_ROT: begin
        // v is pure; conj(a) is exact, so -MIN does not clamp here
        v   = b;
        v.w = 0;
        c   = '{-a.x, -a.y, -a.z, a.w};
        t   = hamilton_mul(a, v, hit);
        r   = hamilton_mul(t, c, hit);
        r.w = 0;
      end
      KIND_ADD: begin
        r.x = clamp32(a.x + b.x, hit);
        r.y = clamp32(a.y + b.y, hit);
        r.z = clamp32(a.z + b.z, hit);
        r.w = clamp32(a.w + b.w, hit);
      end
      KIND_SUB: begin
        r.x = clamp32(a.x - b.x, hit);
        r.y = clamp32(a.y - b.y, hit);
        r.z = clamp32(a.z - b.z, hit);
        r.w = clamp32(a.w - b.w, hit);
      end
      KIND_CONJ: begin
        r.x = clamp32(-a.x, hit);
        r.y = clamp32(-a.y, hit);
        r.z = clamp32(-a.z, hit);
        r.w = a.w;
      end
      default: hit = 1'b0;  // unused kinds give all zeros
    endcase
    res.r_x = comp_t'(r.x);
    res.r_y = comp_t'(r.y);
    res.r_z = comp_t'(r.z);
    res.r_w = comp_t'(r.w);
    res.sat = hit;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random requests
  // ---------------------------------------------------------------------------

  // Mix of extremes, full-range words and small values (about +/-4.0)
  function automatic comp_t rand_comp();
    case ($urandom_range(0, 7))
      0:       return Q_MN;
      1:       return Q_MX;
      2:       return $urandom_range(0, 1) ? Q_M1 : comp_t'(0);
      3, 4:    return comp_t'($urandom());
      default: return comp_t'($urandom_range(0, 524288)) - 32'sd262144;
    endcase
  endfunction

  // Component within +/-1.0, for rotations that stay in range
  function automatic comp_t rand_unit();
    return comp_t'($urandom_range(0, 131072)) - Q_ONE;
  endfunction

  function automatic req_t rand_request();
    req_t q;
    int   sel;
    sel = $urandom_range(0, 15);
    if (sel < 4)       q.kind = KIND_PROD;
    else if (sel < 8)  q.kind = KIND_ROT;
    else if (sel < 10) q.kind = KIND_ADD;
    else if (sel < 12) q.kind = KIND_SUB;
    else if (sel < 14) q.kind = KIND_CONJ;
    else               q.kind = KIND_W'($urandom_range(0, 7));
    q.a_x = rand_comp();
    q.a_y = rand_comp();
    q.a_z = rand_comp();
    q.a_w = rand_comp();
    q.b_x = rand_comp();
    q.b_y = rand_comp();
    q.b_z = rand_comp();
    q.b_w = rand_comp();
    // half of the products and rotations use well-scaled operands
    if ((q.kind == KIND_PROD || q.kind == KIND_ROT) && $urandom_range(0, 1)) begin
      q.a_x = rand_unit();
      q.a_y = rand_unit();
      q.a_z = rand_unit();
      q.a_w = rand_unit();
      q.b_x = comp_t'($urandom_range(0, 524288)) - 32'sd262144;
      q.b_y = comp_t'($urandom_range(0, 524288)) - 32'sd262144;
      q.b_z = comp_t'($urandom_range(0, 524288)) - 32'sd262144;
    end
    return q;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 60) return 0;
    if (r < 90)           return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  task automatic send_req(input req_t q, input res_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= q.kind;
    in_ch.a_x   <= q.a_x;
    in_ch.a_y   <= q.a_y;
    in_ch.a_z   <= q.a_z;
    in_ch.a_w   <= q.a_w;
    in_ch.b_x   <= q.b_x;
    in_ch.b_y   <= q.b_y;
    in_ch.b_z   <= q.b_z;
    in_ch.b_w   <= q.b_w;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(want);
    n_taken++;
  endtask

  initial begin : stim
    req_t q;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= '0;
    in_ch.a_x   <= '0;
    in_ch.a_y   <= '0;
    in_ch.a_z   <= '0;
    in_ch.a_w   <= '0;
    in_ch.b_x   <= '0;
    in_ch.b_y   <= '0;
    in_ch.b_z   <= '0;
    in_ch.b_w   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++) begin
      q = DIR_TAB[i].req;
      send_req(q, DIR_TAB[i].known ? DIR_TAB[i].res : quat_result(q));
    end

    // back-to-back window in the middle of the random part
    for (int i = 0; i < NRAND; i++) begin
      no_gap = (i >= 200 && i < 280);
      q = rand_request();
      send_req(q, quat_result(q));
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold to fill the pipe
  // ---------------------------------------------------------------------------

  initial begin : rsp_side
    int pick;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (!held && n_taken >= 120) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end else if (pick < 15) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (pick < 19) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 30)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Scoring
  task automatic note_mismatch(input string fld, input logic [31:0] want, input logic [31:0] got);
    n_err++;
    $display("%0t: %s expected %h, got %h", $time, fld, want, got);
  endtask

  task automatic score_result();
    res_t want;
    if (pending_results.size() == 0) begin
      n_err++;
      $display("%0t: result with none pending, expected nothing, got %h %h %h %h %b",
               $time, out_ch.r_x, out_ch.r_y, out_ch.r_z, out_ch.r_w, out_ch.saturated);
      return;
    end
    want = pending_results.pop_front();
    if (out_ch.r_x !== want.r_x) note_mismatch("r_x", want.r_x, out_ch.r_x);
    if (out_ch.r_y !== want.r_y) note_mismatch("r_y", want.r_y, out_ch.r_y);
    if (out_ch.r_z !== want.r_z) note_mismatch("r_z", want.r_z, out_ch.r_z);
    if (out_ch.r_w !== want.r_w) note_mismatch("r_w", want.r_w, out_ch.r_w);
    if (out_ch.saturated !== want.sat)
      note_mismatch("saturated", {31'b0, want.sat}, {31'b0, out_ch.saturated});
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      score_result();
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
